FILE: src/cbpg_pkg.sv
// ----------------------------------------------------------------------------
// cbpg_pkg
// Shared constants and controller/datapath handshake types for the cubic
// Bezier point generator.
// ----------------------------------------------------------------------------
package cbpg_pkg;

  localparam int CoordW     = 16;
  localparam int SegW       = 7;
  localparam int IdxW       = 6;
  localparam int MinSeg     = 5;
  localparam int ResultCap  = 64;
  localparam int SegReset   = 10;
  // Dividend 65536 is 17 bits wide, so the serial divider runs 17 steps.
  localparam int DivSteps   = 17;
  localparam int DivCntW    = 5;

  typedef struct packed {
    logic load;
    logic div_step;
    logic wt0;
    logic wt1;
    logic wt2;
    logic mul;
    logic sum;
    logic acc;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic out_free;
  } stat_t;

endpackage

FILE: src/cbpg_ctrl.sv
// ----------------------------------------------------------------------------
// cbpg_ctrl
// Sequencer: per-curve step division, then seven phases per curve point.
// ----------------------------------------------------------------------------
module cbpg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cbpg_pkg::stat_t  stat_i,
  output cbpg_pkg::cmd_t   cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_WT0  = 9'b000000100,
    S_WT1  = 9'b000001000,
    S_WT2  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_SUM  = 9'b001000000,
    S_ACC  = 9'b010000000,
    S_PUSH = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = S_WT0;
        end
      end
      S_WT0: begin
        cmd_o.wt0 = 1'b1;
        state_d   = S_WT1;
      end
      S_WT1: begin
        cmd_o.wt1 = 1'b1;
        state_d   = S_WT2;
      end
      S_WT2: begin
        cmd_o.wt2 = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_PUSH;
      end
      S_PUSH: begin
        // hold the finished point until the output register frees up
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = stat_i.last ? S_IDLE : S_WT0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/cbpg_dp.sv
// ----------------------------------------------------------------------------
// cbpg_dp
// Datapath: segment register, serial step divider, parameter stepping,
// Bernstein weights, split blend products and the output register.
// ----------------------------------------------------------------------------
module cbpg_dp #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic        [cbpg_pkg::SegW-1:0]      cfg_data_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p0_x_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p0_y_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p1_x_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p1_y_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p2_x_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p2_y_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p3_x_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p3_y_i,
  input  cbpg_pkg::cmd_t                        cmd_i,
  output cbpg_pkg::stat_t                       stat_o,
  output logic                                  point_valid_o,
  input  logic                                  point_stall_i,
  output logic signed [cbpg_pkg::CoordW-1:0]    point_x_o,
  output logic signed [cbpg_pkg::CoordW-1:0]    point_y_o,
  output logic        [cbpg_pkg::IdxW-1:0]      point_index_o,
  output logic                                  last_point_o
);

  localparam int CapSeg = (MAX_SEGMENTS < cbpg_pkg::ResultCap) ?
                          MAX_SEGMENTS : cbpg_pkg::ResultCap;
  localparam logic [66:0] RoundHalf = 67'd1 << 47;
  localparam logic [15:0] SignFlip  = 16'h8000;

  // configuration
  logic [6:0] segments_q;
  logic [6:0] seg_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segments_q <= 7'(cbpg_pkg::SegReset);
    end else if (cfg_valid_i) begin
      segments_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (segments_q < 7'(cbpg_pkg::MinSeg)) begin
      seg_eff = 7'(cbpg_pkg::MinSeg);
    end else if (segments_q > 7'(CapSeg)) begin
      seg_eff = 7'(CapSeg);
    end else begin
      seg_eff = segments_q;
    end
  end

  // curve state
  logic [15:0] ux_q [4];
  logic [15:0] uy_q [4];
  logic [6:0]  n_q;
  logic [6:0]  rdiv_q;
  logic [15:0] quot_q;
  logic [cbpg_pkg::DivCntW-1:0] div_cnt_q;
  logic [15:0] t_q;
  logic [6:0]  frac_q;
  logic [5:0]  idx_q;

  // weight and blend pipeline registers
  logic [16:0] r_q;
  logic [17:0] t3_q;
  logic [31:0] t2_q;
  logic [34:0] tr3_q;
  logic [32:0] r2_q;
  logic [48:0] w_q [4];
  logic [39:0] plx_q [4];
  logic [40:0] phx_q [4];
  logic [39:0] ply_q [4];
  logic [40:0] phy_q [4];
  logic [41:0] lox_q, loy_q;
  logic [42:0] hix_q, hiy_q;
  logic [15:0] res_x_q, res_y_q;

  // serial divider: quotient and remainder of 65536 / n
  logic [6:0]  div_sh;
  logic        div_bit;
  logic [6:0]  div_rem_d;
  logic [15:0] div_quot_d;

  always_comb begin
    div_sh = {rdiv_q[5:0], (div_cnt_q == cbpg_pkg::DivCntW'(cbpg_pkg::DivSteps - 1))};
    div_bit = (div_sh >= n_q);
    div_rem_d  = div_bit ? (div_sh - n_q) : div_sh;
    div_quot_d = {quot_q[14:0], div_bit};
  end

  // parameter stepping: t advances by Q, plus one when the remainder carries
  logic [6:0]  frac_sum;
  logic        frac_carry;
  logic [16:0] t_sum;

  always_comb begin
    frac_sum   = frac_q + rdiv_q;
    frac_carry = (frac_sum >= n_q);
    t_sum      = {1'b0, t_q} + {1'b0, quot_q} + {16'd0, frac_carry};
  end

  // weight products
  logic [31:0] t2_p;
  logic [34:0] tr3_p;
  logic [33:0] r2_p;
  logic [49:0] wa_p;
  logic [51:0] wb_p;
  logic [50:0] wc_p;
  logic [47:0] wd_p;

  always_comb begin
    t2_p  = {16'd0, t_q} * {16'd0, t_q};
    tr3_p = {17'd0, t3_q} * {18'd0, r_q};
    r2_p  = {17'd0, r_q} * {17'd0, r_q};
    wa_p  = {17'd0, r2_q} * {33'd0, r_q};
    wb_p  = {17'd0, tr3_q} * {35'd0, r_q};
    wc_p  = {16'd0, tr3_q} * {35'd0, t_q};
    wd_p  = {16'd0, t2_q} * {32'd0, t_q};
  end

  // blend partial products, weights split at bit 24
  logic [39:0] plx_d [4];
  logic [40:0] phx_d [4];
  logic [39:0] ply_d [4];
  logic [40:0] phy_d [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      plx_d[k] = {24'd0, ux_q[k]} * {16'd0, w_q[k][23:0]};
      phx_d[k] = {25'd0, ux_q[k]} * {16'd0, w_q[k][48:24]};
      ply_d[k] = {24'd0, uy_q[k]} * {16'd0, w_q[k][23:0]};
      phy_d[k] = {25'd0, uy_q[k]} * {16'd0, w_q[k][48:24]};
    end
  end

  logic [66:0] acc_x, acc_y;

  assign acc_x = {hix_q, 24'd0} + {25'd0, lox_q} + RoundHalf;
  assign acc_y = {hiy_q, 24'd0} + {25'd0, loy_q} + RoundHalf;

  logic last_pt;
  assign last_pt = ({1'b0, idx_q} == (n_q - 7'd1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ux_q[0]   <= $unsigned(p0_x_i) ^ SignFlip;
      ux_q[1]   <= $unsigned(p1_x_i) ^ SignFlip;
      ux_q[2]   <= $unsigned(p2_x_i) ^ SignFlip;
      ux_q[3]   <= $unsigned(p3_x_i) ^ SignFlip;
      uy_q[0]   <= $unsigned(p0_y_i) ^ SignFlip;
      uy_q[1]   <= $unsigned(p1_y_i) ^ SignFlip;
      uy_q[2]   <= $unsigned(p2_y_i) ^ SignFlip;
      uy_q[3]   <= $unsigned(p3_y_i) ^ SignFlip;
      n_q       <= seg_eff;
      rdiv_q    <= '0;
      quot_q    <= '0;
      div_cnt_q <= cbpg_pkg::DivCntW'(cbpg_pkg::DivSteps - 1);
      t_q       <= '0;
      frac_q    <= '0;
      idx_q     <= '0;
    end
    if (cmd_i.div_step) begin
      rdiv_q    <= div_rem_d;
      quot_q    <= div_quot_d;
      div_cnt_q <= div_cnt_q - cbpg_pkg::DivCntW'(1);
    end
    if (cmd_i.wt0) begin
      r_q  <= 17'h10000 - {1'b0, t_q};
      t3_q <= {2'd0, t_q} + {1'b0, t_q, 1'b0};
    end
    if (cmd_i.wt1) begin
      t2_q  <= t2_p;
      tr3_q <= tr3_p;
      r2_q  <= r2_p[32:0];
    end
    if (cmd_i.wt2) begin
      w_q[0] <= wa_p[48:0];
      w_q[1] <= wb_p[48:0];
      w_q[2] <= wc_p[48:0];
      w_q[3] <= {1'b0, wd_p};
    end
    if (cmd_i.mul) begin
      for (int k = 0; k < 4; k++) begin
        plx_q[k] <= plx_d[k];
        phx_q[k] <= phx_d[k];
        ply_q[k] <= ply_d[k];
        phy_q[k] <= phy_d[k];
      end
    end
    if (cmd_i.sum) begin
      lox_q <= 42'(plx_q[0]) + 42'(plx_q[1]) + 42'(plx_q[2]) + 42'(plx_q[3]);
      hix_q <= 43'(phx_q[0]) + 43'(phx_q[1]) + 43'(phx_q[2]) + 43'(phx_q[3]);
      loy_q <= 42'(ply_q[0]) + 42'(ply_q[1]) + 42'(ply_q[2]) + 42'(ply_q[3]);
      hiy_q <= 43'(phy_q[0]) + 43'(phy_q[1]) + 43'(phy_q[2]) + 43'(phy_q[3]);
    end
    if (cmd_i.acc) begin
      res_x_q <= acc_x[63:48] ^ SignFlip;
      res_y_q <= acc_y[63:48] ^ SignFlip;
    end
    if (cmd_i.push && !last_pt) begin
      t_q    <= t_sum[15:0];
      frac_q <= frac_carry ? (frac_sum - n_q) : frac_sum;
      idx_q  <= idx_q + 6'd1;
    end
  end

  // output register
  logic        out_valid_q;
  logic [15:0] out_x_q, out_y_q;
  logic [5:0]  out_idx_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!point_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_x_q    <= res_x_q;
      out_y_q    <= res_y_q;
      out_idx_q  <= idx_q;
      out_last_q <= last_pt;
    end
  end

  assign point_valid_o = out_valid_q;
  assign point_x_o     = $signed(out_x_q);
  assign point_y_o     = $signed(out_y_q);
  assign point_index_o = out_idx_q;
  assign last_point_o  = out_last_q;

  assign stat_o.div_done = (div_cnt_q == '0);
  assign stat_o.last     = last_pt;
  assign stat_o.out_free = !out_valid_q || !point_stall_i;

endmodule

FILE: src/cubic_bezier_point_generator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator
// Evaluates a cubic Bezier curve at n evenly spaced parameters t = i/n.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one curve item: four signed
//   Q12.4 control points. Output channel (point_valid_o / point_stall_i)
//   returns n point items, index 0 to n-1, last_point_o set on the final one.
//   The cfg channel (cfg_valid_i / cfg_ready_o) writes the segment count n,
//   clamped to 5 .. min(MAX_SEGMENTS, 64); write it only while idle.
//   A curve first runs a serial division (65536 / n) that sets the
//   parameter step, then takes each point in turn through the weight and
//   blend stages.
//   A new curve is accepted once the last point has entered the output
//   register. When the receiver stalls, the point in the output register
//   holds, the next point is computed and waits until that one is taken.
//   Reset empties the output register, returns to idle and sets n to 10.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [cbpg_pkg::SegW-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p0_x_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p0_y_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p1_x_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p1_y_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p2_x_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p2_y_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p3_x_i,
  input  logic signed [cbpg_pkg::CoordW-1:0]    p3_y_i,
  output logic                                  point_valid_o,
  input  logic                                  point_stall_i,
  output logic signed [cbpg_pkg::CoordW-1:0]    point_x_o,
  output logic signed [cbpg_pkg::CoordW-1:0]    point_y_o,
  output logic        [cbpg_pkg::IdxW-1:0]      point_index_o,
  output logic                                  last_point_o
);

  cbpg_pkg::cmd_t  cmd;
  cbpg_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  cbpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cbpg_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .p0_x_i        (p0_x_i),
    .p0_y_i        (p0_y_i),
    .p1_x_i        (p1_x_i),
    .p1_y_i        (p1_y_i),
    .p2_x_i        (p2_x_i),
    .p2_y_i        (p2_y_i),
    .p3_x_i        (p3_x_i),
    .p3_y_i        (p3_y_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .point_valid_o (point_valid_o),
    .point_stall_i (point_stall_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_index_o (point_index_o),
    .last_point_o  (last_point_o)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cubic_bezier_point_generator. Curves go in through
// a queue-fed driver, and every point that comes out is checked against
// points computed here in Q0.48 fixed point. The run steps through a range of
// segment counts, including clamped writes, and mixes sender gaps, receiver
// stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int          MaxSegments = 64;
  localparam int          SegCap      = (MaxSegments < cbpg_pkg::ResultCap) ?
                                        MaxSegments : cbpg_pkg::ResultCap;
  localparam int unsigned RandomItems = 410;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 2_000_000;

  localparam logic signed [cbpg_pkg::CoordW-1:0] CMin = -16'sd32768;
  localparam logic signed [cbpg_pkg::CoordW-1:0] CMax = 16'sd32767;

  typedef struct packed {
    logic signed [cbpg_pkg::CoordW-1:0] p0_x;
    logic signed [cbpg_pkg::CoordW-1:0] p0_y;
    logic signed [cbpg_pkg::CoordW-1:0] p1_x;
    logic signed [cbpg_pkg::CoordW-1:0] p1_y;
    logic signed [cbpg_pkg::CoordW-1:0] p2_x;
    logic signed [cbpg_pkg::CoordW-1:0] p2_y;
    logic signed [cbpg_pkg::CoordW-1:0] p3_x;
    logic signed [cbpg_pkg::CoordW-1:0] p3_y;
  } curve_t;

  typedef struct packed {
    logic signed [cbpg_pkg::CoordW-1:0] x;
    logic signed [cbpg_pkg::CoordW-1:0] y;
    logic        [cbpg_pkg::IdxW-1:0]   idx;
    logic                               last;
  } point_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic        [cbpg_pkg::SegW-1:0]   cfg_data_i = '0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic signed [cbpg_pkg::CoordW-1:0] p0_x_i = '0;
  logic signed [cbpg_pkg::CoordW-1:0] p0_y_i = '0;
  logic signed [cbpg_pkg::CoordW-1:0] p1_x_i = '0;
  logic signed [cbpg_pkg::CoordW-1:0] p1_y_i = '0;
  logic signed [cbpg_pkg::CoordW-1:0] p2_x_i = '0;
  logic signed [cbpg_pkg::CoordW-1:0] p2_y_i = '0;
  logic signed [cbpg_pkg::CoordW-1:0] p3_x_i = '0;
  logic signed [cbpg_pkg::CoordW-1:0] p3_y_i = '0;
  logic                               point_valid_o;
  logic                               point_stall_i = 1'b0;
  logic signed [cbpg_pkg::CoordW-1:0] point_x_o;
  logic signed [cbpg_pkg::CoordW-1:0] point_y_o;
  logic        [cbpg_pkg::IdxW-1:0]   point_index_o;
  logic                               last_point_o;

  curve_t      pending_curves[$];
  point_t      predicted_points[$];
  logic [cbpg_pkg::SegW-1:0] seg_reg = cbpg_pkg::SegW'(cbpg_pkg::SegReset);
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        curve_taken = 1'b0;
  logic        long_stall = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned curves_queued = 0;
  int unsigned curves_taken = 0;
  int unsigned points_seen = 0;
  int unsigned settings_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  int unsigned corner_segments[6] = '{0, 127, 4, 65, cbpg_pkg::MinSeg, SegCap};
  int unsigned idle_by_mode[4] = '{0, 68, 0, 23};
  int unsigned stall_by_mode[4] = '{0, 0, 68, 23};

  cubic_bezier_point_generator #(
    .MAX_SEGMENTS(MaxSegments)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .p0_x_i        (p0_x_i),
    .p0_y_i        (p0_y_i),
    .p1_x_i        (p1_x_i),
    .p1_y_i        (p1_y_i),
    .p2_x_i        (p2_x_i),
    .p2_y_i        (p2_y_i),
    .p3_x_i        (p3_x_i),
    .p3_y_i        (p3_y_i),
    .point_valid_o (point_valid_o),
    .point_stall_i (point_stall_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_index_o (point_index_o),
    .last_point_o  (last_point_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned effective_segments(logic [cbpg_pkg::SegW-1:0] value);
    int unsigned n;
    n = value;
    if (n < cbpg_pkg::MinSeg) n = cbpg_pkg::MinSeg;
    if (n > SegCap) n = SegCap;
    return n;
  endfunction

  // Shift each coordinate to offset binary, blend exactly, round half up.
  function automatic logic [cbpg_pkg::CoordW-1:0] blend_axis(
    logic [cbpg_pkg::CoordW-1:0] c0, logic [cbpg_pkg::CoordW-1:0] c1,
    logic [cbpg_pkg::CoordW-1:0] c2, logic [cbpg_pkg::CoordW-1:0] c3,
    bit [63:0] wa, bit [63:0] wb, bit [63:0] wc, bit [63:0] wd
  );
    bit [63:0] acc;
    acc = 64'({~c0[cbpg_pkg::CoordW-1], c0[cbpg_pkg::CoordW-2:0]}) * wa
        + 64'({~c1[cbpg_pkg::CoordW-1], c1[cbpg_pkg::CoordW-2:0]}) * wb
        + 64'({~c2[cbpg_pkg::CoordW-1], c2[cbpg_pkg::CoordW-2:0]}) * wc
        + 64'({~c3[cbpg_pkg::CoordW-1], c3[cbpg_pkg::CoordW-2:0]}) * wd;
    acc = (acc + (64'd1 << 47)) >> 48;
    return acc[cbpg_pkg::CoordW-1:0] ^ 16'h8000;
  endfunction

  function automatic void predict_points(curve_t c);
    int unsigned n;
    int unsigned i;
    bit [63:0]   t;
    bit [63:0]   r;
    bit [63:0]   wa;
    bit [63:0]   wb;
    bit [63:0]   wc;
    bit [63:0]   wd;
    point_t      p;
    n = effective_segments(seg_reg);
    for (i = 0; i < n; i++) begin
      t  = (64'(i) << 16) / 64'(n);
      r  = 64'd65536 - t;
      wa = r * r * r;
      wb = 64'd3 * t * r * r;
      wc = 64'd3 * t * t * r;
      wd = t * t * t;
      p.x    = blend_axis(c.p0_x, c.p1_x, c.p2_x, c.p3_x, wa, wb, wc, wd);
      p.y    = blend_axis(c.p0_y, c.p1_y, c.p2_y, c.p3_y, wa, wb, wc, wd);
      p.idx  = cbpg_pkg::IdxW'(i);
      p.last = (i + 1 == n);
      predicted_points.push_back(p);
    end
  endfunction

  function automatic logic signed [cbpg_pkg::CoordW-1:0] random_coord();
    case ($urandom_range(0, 9)) inside
      0:       return CMin;
      1:       return CMax;
      2, 3:    return cbpg_pkg::CoordW'($urandom_range(0, 255) - 128);
      default: return cbpg_pkg::CoordW'($urandom);
    endcase
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    c.p0_x = random_coord();
    c.p0_y = random_coord();
    c.p1_x = random_coord();
    c.p1_y = random_coord();
    c.p2_x = random_coord();
    c.p2_y = random_coord();
    c.p3_x = random_coord();
    c.p3_y = random_coord();
    return c;
  endfunction

  function automatic logic [cbpg_pkg::SegW-1:0] random_segments();
    case ($urandom_range(0, 9))
      0:       return cbpg_pkg::SegW'($urandom_range(0, cbpg_pkg::MinSeg - 1));
      1:       return cbpg_pkg::SegW'($urandom_range(SegCap + 1, (1 << cbpg_pkg::SegW) - 1));
      2:       return cbpg_pkg::SegW'(SegCap);
      default: return cbpg_pkg::SegW'($urandom_range(cbpg_pkg::MinSeg, 16));
    endcase
  endfunction

  task automatic push_curve(input curve_t c);
    pending_curves.push_back(c);
    curves_queued++;
  endtask

  // Hold until every queued curve is taken and all its points have come out.
  task automatic settle();
    while (curves_taken != curves_queued || predicted_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_segments(input logic [cbpg_pkg::SegW-1:0] value);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    seg_reg = value;
    settings_cnt++;
    @(negedge clk);
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input int unsigned mode);
    send_idle_pct = idle_by_mode[mode % 4];
    stall_pct     = stall_by_mode[mode % 4];
  endtask

  // Curve driver: present the next item once the current one is taken.
  always @(negedge clk) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || curve_taken) begin
      if (pending_curves.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        p0_x_i     <= pending_curves[0].p0_x;
        p0_y_i     <= pending_curves[0].p0_y;
        p1_x_i     <= pending_curves[0].p1_x;
        p1_y_i     <= pending_curves[0].p1_y;
        p2_x_i     <= pending_curves[0].p2_x;
        p2_y_i     <= pending_curves[0].p2_y;
        p3_x_i     <= pending_curves[0].p3_x;
        p3_y_i     <= pending_curves[0].p3_y;
        void'(pending_curves.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    point_stall_i <= long_stall || ($urandom_range(0, 99) < stall_pct);
  end

  // Long output hold-off while the sender keeps offering curves.
  initial begin : point_hold
    int unsigned k;
    wait (hold_req);
    @(negedge clk);
    long_stall <= 1'b1;
    for (k = 0; k < HoldCycles; k++) @(negedge clk);
    long_stall <= 1'b0;
  end

  always @(posedge clk) begin : monitor
    curve_t c;
    point_t want;
    point_t got;
    curve_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      c = '{p0_x_i, p0_y_i, p1_x_i, p1_y_i, p2_x_i, p2_y_i, p3_x_i, p3_y_i};
      predict_points(c);
      curves_taken++;
    end
    if (rst_ni && point_valid_o && !point_stall_i) begin
      got = '{point_x_o, point_y_o, point_index_o, last_point_o};
      points_seen++;
      if (predicted_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point x=%0d y=%0d idx=%0d last=%0b", $time,
                 got.x, got.y, got.idx, got.last);
      end else begin
        want = predicted_points.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: point mismatch, expected x=%0d y=%0d idx=%0d last=%0b", $time,
                   want.x, want.y, want.idx, want.last);
          $display("%0t:                 actual   x=%0d y=%0d idx=%0d last=%0b", $time,
                   got.x, got.y, got.idx, got.last);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles, %0d points still pending", $time, cycle_cnt,
             predicted_points.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    curve_t      c;
    int unsigned k;
    int unsigned phase;
    int unsigned count;
    int unsigned random_done;
    logic [cbpg_pkg::SegW-1:0] seg;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed curves at the reset segment count, no idling.
    set_mode(0);
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    push_curve(c);
    c = '{CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax};
    push_curve(c);
    c = '{CMin, CMin, CMin, CMin, CMin, CMin, CMin, CMin};
    push_curve(c);
    c = '{CMin, CMax, CMin, CMax, CMax, CMin, CMax, CMin};
    push_curve(c);
    c = '{CMax, CMin, CMin, CMax, CMax, CMin, CMin, CMax};
    push_curve(c);
    c = '{CMin, CMin, CMin, CMin, CMax, CMax, CMax, CMax};
    push_curve(c);
    c = '{-16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1};
    push_curve(c);
    c = '{-16'sd160, 16'sd80, -16'sd48, 16'sd16, 16'sd48, -16'sd16, 16'sd160, -16'sd80};
    push_curve(c);
    settle();

    // Segment count extremes, including writes that must clamp.
    for (k = 0; k < 6; k++) begin
      write_segments(cbpg_pkg::SegW'(corner_segments[k]));
      set_mode(k);
      c = '{CMin, CMax, CMax, CMin, CMin, CMax, CMax, CMin};
      push_curve(c);
      push_curve(random_curve());
      settle();
    end

    // Random phases; one of them holds the output off for a long stretch.
    phase = 0;
    random_done = 0;
    while (random_done < RandomItems) begin
      if (phase == 5) begin
        write_segments(cbpg_pkg::SegW'(cbpg_pkg::SegReset));
        set_mode(0);
        for (k = 0; k < 40; k++) push_curve(random_curve());
        hold_req = 1'b1;
        random_done += 40;
      end else begin
        seg = random_segments();
        write_segments(seg);
        set_mode(phase);
        count = (effective_segments(seg) > 16) ? $urandom_range(3, 8) : $urandom_range(15, 35);
        for (k = 0; k < count; k++) push_curve(random_curve());
        random_done += count;
      end
      settle();
      phase++;
    end

    repeat (DrainCycles) @(posedge clk);
    if (predicted_points.size() != 0) begin
      errors++;
      $display("%0t: %0d expected points never arrived", $time, predicted_points.size());
    end
    $display("Ran %0d curves, %0d points checked, %0d segment writes incl. clamped values.",
             curves_taken, points_seen, settings_cnt);
    $display("Idle mixes: none, sender gaps, receiver stalls, both, plus a long output hold.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
